// ----- design/idtp_pkg.sv -----
package idtp_pkg;

	// Character codes of interest
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Field widths fixed by the string format
	localparam int OCTET_W = 8;
	localparam int GROUP_W = 10;
	localparam int POS_W   = 5;
	localparam int NUM_GROUPS = 4;

	localparam logic [POS_W-1:0] POS_SAT    = 5'd31;
	localparam logic [1:0]       DIGITS_MAX = 2'd3;
	localparam logic [1:0]       LAST_GROUP = 2'd3;

	typedef logic [OCTET_W-1:0] octet_t;

	typedef enum logic [1:0] {
		CC_NUL,
		CC_DOT,
		CC_DIGIT,
		CC_OTHER
	} char_class_t;

	// One character handed to the parser core
	typedef struct packed {
		logic       go;
		logic [7:0] ch;
	} step_t;

	// One parse result
	typedef struct packed {
		logic   ok;
		octet_t octet0;
		octet_t octet1;
		octet_t octet2;
		octet_t octet3;
	} result_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cc;
		case (c) inside
			CH_NUL:             cc = CC_NUL;
			CH_DOT:             cc = CC_DOT;
			[CH_ZERO:CH_NINE]:  cc = CC_DIGIT;
			default:            cc = CC_OTHER;
		endcase
		return cc;
	endfunction

endpackage

// ----- design/idtp_core.sv -----
module idtp_core #(
	parameter int MAX_CHARS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  idtp_pkg::step_t  step,
	output idtp_pkg::result_t result
);
	import idtp_pkg::*;

	logic [GROUP_W-1:0] gv_q, gv_d;
	logic [1:0]         dc_q, dc_d;
	logic               fz_q, fz_d;
	logic [1:0]         gi_q, gi_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               err_q, err_d;
	octet_t             octet_q [NUM_GROUPS];

	char_class_t        cc;
	logic [3:0]         digit;
	logic [GROUP_W-1:0] gv_x10;
	logic               pos_lim;
	logic               close_ok;
	logic               store_wr;
	logic               good;

	assign cc       = classify(step.ch);
	assign digit    = 4'(step.ch - CH_ZERO);
	// value * 10 as (v << 3) + (v << 1), kept to the group width
	assign gv_x10   = {gv_q[GROUP_W-4:0], 3'b000} + {gv_q[GROUP_W-2:0], 1'b0};
	assign pos_lim  = (pos_q >= POS_W'(MAX_CHARS));
	// group closes cleanly: has digits, no leading zero, fits in an octet
	assign close_ok = (dc_q != 2'd0) && !((dc_q != 2'd1) && fz_q)
		&& (gv_q[GROUP_W-1:OCTET_W] == '0);

	// Next-state logic for one character
	always_comb begin
		gv_d     = gv_q;
		dc_d     = dc_q;
		fz_d     = fz_q;
		gi_d     = gi_q;
		pos_d    = pos_q;
		err_d    = err_q;
		store_wr = 1'b0;
		if (step.go) begin
			if (cc == CC_NUL) begin
				gv_d  = '0;
				dc_d  = '0;
				fz_d  = 1'b0;
				gi_d  = '0;
				pos_d = '0;
				err_d = 1'b0;
			end else begin
				if (!err_q) begin
					if (pos_lim) begin
						err_d = 1'b1;
					end else begin
						case (cc)
							CC_DOT: begin
								if (!close_ok || (gi_q == LAST_GROUP)) begin
									err_d = 1'b1;
								end else begin
									store_wr = 1'b1;
									gi_d     = gi_q + 2'd1;
									gv_d     = '0;
									dc_d     = '0;
									fz_d     = 1'b0;
								end
							end
							CC_DIGIT: begin
								if (dc_q == DIGITS_MAX) begin
									err_d = 1'b1;
								end else begin
									if (dc_q == 2'd0)
										fz_d = (digit == 4'd0);
									gv_d = gv_x10 + {{(GROUP_W-4){1'b0}}, digit};
									dc_d = dc_q + 2'd1;
								end
							end
							default: begin
								err_d = 1'b1;
							end
						endcase
					end
				end
				if (pos_q != POS_SAT)
					pos_d = pos_q + 5'd1;
			end
		end
	end

	// Result seen on the terminator; the open group is the last octet
	always_comb begin
		good          = !err_q && !pos_lim && close_ok && (gi_q == LAST_GROUP);
		result.ok     = good;
		result.octet0 = good ? octet_q[0] : '0;
		result.octet1 = good ? octet_q[1] : '0;
		result.octet2 = good ? octet_q[2] : '0;
		result.octet3 = good ? gv_q[OCTET_W-1:0] : '0;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_q  <= '0;
			dc_q  <= '0;
			fz_q  <= 1'b0;
			gi_q  <= '0;
			pos_q <= '0;
			err_q <= 1'b0;
		end else begin
			gv_q  <= gv_d;
			dc_q  <= dc_d;
			fz_q  <= fz_d;
			gi_q  <= gi_d;
			pos_q <= pos_d;
			err_q <= err_d;
		end
	end

	// Captured octets, no reset
	always_ff @(posedge clk) begin
		if (store_wr)
			octet_q[gi_q] <= gv_q[OCTET_W-1:0];
	end

endmodule

// ----- design/idtp_out_stage.sv -----
module idtp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  idtp_pkg::result_t res_in,
	input  logic              out_stall,
	output logic              slot_free,
	output logic              out_valid,
	output idtp_pkg::result_t res_out
);
	import idtp_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Slot frees up when empty or when the held result transfers this cycle
	assign slot_free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

endmodule

// ----- design/ipv4_dotted_text_parser.sv -----
// Streaming dotted-decimal IPv4 parser.
// Input channel: one character per transfer on ch (in_valid / in_stall).
// A zero byte ends the string. Output channel: one result per string
// (out_valid / out_stall) carrying ok and octet0..octet3 in written order;
// the octets read zero when ok is low.
// A transferred character sits in the input register and is parsed from
// there; a parsed terminator loads its result into the output register.
// Throughput: one character per cycle while in_stall is low, set by the
// combinational update (group value times ten plus digit) and checks.
// Reset clears all parse state and empties both registers; the octet
// store needs no reset since only octets written for the current string
// are ever shown.
// When the receiver stalls, the result stays in the output register; a
// following terminator waits in the input register and in_stall rises,
// while ordinary characters keep flowing since they make no result.
module ipv4_dotted_text_parser #(
	parameter int MAX_CHARS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           ch,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output idtp_pkg::octet_t     octet0,
	output idtp_pkg::octet_t     octet1,
	output idtp_pkg::octet_t     octet2,
	output idtp_pkg::octet_t     octet3
);
	import idtp_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       slot_free;
	logic       is_nul_s1;
	logic       go;
	logic       res_load;
	step_t      step;
	result_t    res_core;
	result_t    res_out;

	// Input register advance
	assign is_nul_s1 = (ch_s1 == CH_NUL);
	assign go        = valid_s1 && (!is_nul_s1 || slot_free);
	assign res_load  = go && is_nul_s1;
	assign in_stall  = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			ch_s1 <= ch;
	end

	assign step.go = go;
	assign step.ch = ch_s1;

	idtp_core #(
		.MAX_CHARS(MAX_CHARS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (res_core)
	);

	idtp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res_in    (res_core),
		.out_stall (out_stall),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign ok     = res_out.ok;
	assign octet0 = res_out.octet0;
	assign octet1 = res_out.octet1;
	assign octet2 = res_out.octet2;
	assign octet3 = res_out.octet3;

`ifndef SYNTH
	// A failed parse never shows stale octets
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> ((octet0 == '0) && (octet1 == '0)
			&& (octet2 == '0) && (octet3 == '0)))
		else $error("nonzero octets on failed parse");

	// Only a held terminator may back-pressure the input
	a_stall_on_nul: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && is_nul_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked terminator");

	// A parsed terminator shows up as a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> out_valid)
		else $error("terminator parsed but no result offered");
`endif

endmodule

// ----- verif/tb_ipv4_dotted_text_parser.sv -----
module tb_ipv4_dotted_text_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import idtp_pkg::*;

	localparam int MAX_CHARS      = 16;
	localparam int RANDOM_CHARS   = 1850;
	localparam int WATCHDOG_LIMIT = 2000;

	// Tracks the parse of the character stream and holds the results still owed
	class quad_scoreboard;
		logic [GROUP_W-1:0] grp_val;
		logic [1:0]         n_digits;
		logic               lead_zero;
		logic [1:0]         grp_idx;
		octet_t             octs[NUM_GROUPS];
		logic [POS_W-1:0]   pos;
		logic               err;
		result_t            quads_due[$];
		int                 mismatches;
		int                 chars_seen;
		int                 quads_checked;
		int                 quads_ok;

		function new();
			mismatches = 0;
			chars_seen = 0;
			quads_checked = 0;
			quads_ok = 0;
			clear();
		endfunction

		function void clear();
			grp_val = '0;
			n_digits = '0;
			lead_zero = 1'b0;
			grp_idx = '0;
			foreach (octs[i]) octs[i] = '0;
			pos = '0;
			err = 1'b0;
		endfunction

		// Validate the group being closed and capture it as an octet
		function bit close_group();
			if (n_digits == 2'd0)
				return 1'b0;
			if (n_digits != 2'd1 && lead_zero)
				return 1'b0;
			if (grp_val > 10'd255)
				return 1'b0;
			octs[grp_idx] = grp_val[OCTET_W-1:0];
			return 1'b1;
		endfunction

		function void take_char(logic [7:0] c);
			result_t r;
			bit good;
			logic [3:0] d;
			chars_seen++;
			// terminator: report and start over
			if (c == CH_NUL) begin
				good = !err;
				if (good && pos >= MAX_CHARS)
					good = 1'b0;
				if (good && !close_group())
					good = 1'b0;
				if (good && grp_idx != LAST_GROUP)
					good = 1'b0;
				r.ok = good;
				r.octet0 = good ? octs[0] : '0;
				r.octet1 = good ? octs[1] : '0;
				r.octet2 = good ? octs[2] : '0;
				r.octet3 = good ? octs[3] : '0;
				quads_due.push_back(r);
				clear();
				return;
			end
			if (!err) begin
				if (pos >= MAX_CHARS) begin
					err = 1'b1;
				end else if (c == CH_DOT) begin
					if (!close_group() || grp_idx >= LAST_GROUP) begin
						err = 1'b1;
					end else begin
						grp_idx = grp_idx + 2'd1;
						grp_val = '0;
						n_digits = '0;
						lead_zero = 1'b0;
					end
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					if (n_digits >= DIGITS_MAX) begin
						err = 1'b1;
					end else begin
						d = 4'(c - CH_ZERO);
						if (n_digits == 2'd0)
							lead_zero = (d == 4'd0);
						grp_val = GROUP_W'(grp_val * 10 + d);
						n_digits = n_digits + 2'd1;
					end
				end else begin
					err = 1'b1;
				end
			end
			if (pos < POS_SAT)
				pos = pos + 1'b1;
		endfunction

		function void verify_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_quad(logic k, octet_t a, octet_t b, octet_t c, octet_t d);
			result_t e;
			if (quads_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual ok=%0b %0d.%0d.%0d.%0d",
					$time, k, a, b, c, d);
				mismatches++;
				return;
			end
			e = quads_due.pop_front();
			quads_checked++;
			if (e.ok)
				quads_ok++;
			verify_field("ok", 8'(e.ok), 8'(k));
			verify_field("octet0", e.octet0, a);
			verify_field("octet1", e.octet1, b);
			verify_field("octet2", e.octet2, c);
			verify_field("octet3", e.octet3, d);
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] ch = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       ok;
	octet_t     octet0;
	octet_t     octet1;
	octet_t     octet2;
	octet_t     octet3;

	int snd_idle_pct = 25;
	int rcv_idle_pct = 60;
	int quiet_cycles = 0;

	quad_scoreboard sb = new();

	ipv4_dotted_text_parser #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.octet0(octet0),
		.octet1(octet1),
		.octet2(octet2),
		.octet3(octet3)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// Monitor both channels; count cycles with no transfer
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.take_char(ch);
		if (arst_n && out_valid && !out_stall)
			sb.check_quad(ok, octet0, octet1, octet2, octet3);
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("ipv4_dotted_text_parser test failed");
		$finish;
	end

	// One character transfer, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// A string body followed by its terminator
	task automatic send_line(input logic [7:0] q[$]);
		foreach (q[i]) send_char(q[i]);
		send_char(CH_NUL);
	endtask

	function automatic void push_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
	endfunction

	task automatic send_text(input string s);
		logic [7:0] q[$];
		push_text(q, s);
		send_line(q);
	endtask

	// Decimal text of one group; bad ones break a single rule
	function automatic string group_text(input bit bad);
		int v;
		if (bad) begin
			case ($urandom_range(2))
				0: return $sformatf("0%0d", $urandom_range(99));
				1: return $sformatf("%0d", $urandom_range(256, 999));
				default: return $sformatf("%0d", $urandom_range(1000, 9999));
			endcase
		end
		case ($urandom_range(4))
			0: v = 0;
			1: v = 255;
			default: v = $urandom_range(255);
		endcase
		return $sformatf("%0d", v);
	endfunction

	// Mostly dotted quads, some damaged ones, some noise
	task automatic send_random_string(output int n);
		logic [7:0] q[$];
		int kind;
		int groups;
		int bad_at;
		int flaw;
		int len;
		int pick;
		kind = $urandom_range(99);
		if (kind < 75) begin
			groups = 4;
			bad_at = -1;
			flaw = (kind < 55) ? -1 : $urandom_range(5);
			if (flaw == 0)
				bad_at = $urandom_range(3);
			if (flaw == 1)
				groups = $urandom_range(1, 3);
			if (flaw == 2)
				groups = $urandom_range(5, 6);
			for (int k = 0; k < groups; k++) begin
				if (k != 0)
					q.push_back(CH_DOT);
				push_text(q, group_text(k == bad_at));
			end
			if (flaw == 3)
				q[$urandom_range(q.size() - 1)] = 8'($urandom_range(1, 255));
			if (flaw == 4)
				q.delete($urandom_range(q.size() - 1));
			if (flaw == 5)
				q.insert($urandom_range(q.size()), CH_DOT);
		end else begin
			len = ($urandom_range(9) == 0) ? $urandom_range(41) : $urandom_range(20);
			repeat (len) begin
				if ($urandom_range(1)) begin
					pick = $urandom_range(10);
					q.push_back((pick == 10) ? CH_DOT : 8'(CH_ZERO + pick));
				end else begin
					q.push_back(8'($urandom_range(255)));
				end
			end
		end
		send_line(q);
		n = q.size() + 1;
	endtask

	// Drop valid and let every owed result come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.quads_due.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int snd, input int rcv, input int chars);
		int sent;
		int n;
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		sent = 0;
		while (sent < chars) begin
			send_random_string(n);
			sent += n;
		end
		drain();
	endtask

	initial begin
		logic [7:0] q[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: extremes and each rule break
		snd_idle_pct = 25;
		rcv_idle_pct = 60;
		send_text("0.0.0.0");
		send_text("255.255.255.255");
		send_text("1.2.3.4");
		send_text("1.2.3.a");
		q = '{8'hFF};
		send_line(q);
		send_text("");
		send_text("1234.1.1.1");
		send_text("1..2.3");
		send_text("1.2.3.");
		send_text("01.2.3.4");
		send_text("1.2.3.00");
		send_text("256.1.1.1");
		send_text("1.2.3.4.5");
		send_text("1.2.3");
		// long string that saturates the position counter
		send_text("1.2.3.4.5.6.7.8.9.10.11.12.13.14.15.16.17");
		send_text("10.100.199.9");
		drain();

		run_phase(25, 60, RANDOM_CHARS / 3);
		run_phase(60, 25, RANDOM_CHARS / 3);
		run_phase(0, 0, RANDOM_CHARS - 2 * (RANDOM_CHARS / 3));

		repeat (4) @(posedge clk);
		foreach (sb.quads_due[i]) begin
			$display("%0t: missing result, expected ok=%0b %0d.%0d.%0d.%0d, actual none", $time,
				sb.quads_due[i].ok, sb.quads_due[i].octet0, sb.quads_due[i].octet1,
				sb.quads_due[i].octet2, sb.quads_due[i].octet3);
			sb.mismatches++;
		end
		$display("Sent %0d characters; checked %0d parse results, %0d of them valid quads.",
			sb.chars_seen, sb.quads_checked, sb.quads_ok);
		$display("Ran with sender and receiver idling in turn, then at full rate.");
		if (sb.mismatches == 0) begin
			$display("ipv4_dotted_text_parser test passed");
		end else begin
			$display("ipv4_dotted_text_parser test failed");
		end
		$finish;
	end

endmodule
